// File: rtl/core/irc_pkg.sv
// ----------------------------------------------------------------------------
// irc_pkg
// Shared types and constants for the IPv4 range to CIDR block decomposer.
// ----------------------------------------------------------------------------
package irc_pkg;

    localparam int FieldBits   = 32;
    localparam int PrefixBits  = 6;
    localparam int MaxBlocks   = 62;
    localparam int CountBits   = 6;
    localparam int QueueDepth  = 2;
    localparam int QueuePtrW   = 1;
    localparam int QueueCountW = 2;

    typedef struct packed {
        logic [FieldBits-1:0] range_start;
        logic [FieldBits-1:0] range_end;
    } range_t;

    typedef struct packed {
        logic [FieldBits-1:0]  block_base;
        logic [PrefixBits-1:0] prefix_length;
        logic                  range_error;
        logic                  last_block;
    } block_t;

    // one classified range waiting for the walker
    typedef struct packed {
        range_t rng;
        logic   bad;
    } walk_cmd_t;

    // queue status as seen from both sides
    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_stat_t;

endpackage

// File: rtl/core/ip_range_to_cidr_blocks.sv
// ----------------------------------------------------------------------------
// ip_range_to_cidr_blocks
// Splits an inclusive address range into the minimal ascending set of CIDR blocks.
// ----------------------------------------------------------------------------
// The first block passes through the queue entry, the walker range registers and the output register.
// Throughput: one block per cycle while block_stall is low; a range yields at most
//   62 blocks, a limit set by the walker's block count.
// A two-entry queue lets new ranges transfer while the walker is busy.
// Reset: asynchronous active low; clears queue, walker and output valid.
module ip_range_to_cidr_blocks #(
    parameter int ADDRESS_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            range_valid,
    output logic            range_stall,
    input  irc_pkg::range_t range_item,
    output logic            block_valid,
    input  logic            block_stall,
    output irc_pkg::block_t block_item
);
    import irc_pkg::*;

    queue_stat_t qstat;
    logic        push;
    logic        pop;
    walk_cmd_t   push_cmd;
    walk_cmd_t   head_cmd;

    irc_front #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .range_valid (range_valid),
        .range_stall (range_stall),
        .range_item  (range_item),
        .qstat       (qstat),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    irc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    irc_walk #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .qstat       (qstat),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .block_valid (block_valid),
        .block_stall (block_stall),
        .block_item  (block_item)
    );

endmodule

// File: rtl/core/irc_front.sv
// ----------------------------------------------------------------------------
// irc_front
// Accepts ranges, compares them at the address width and flags rejected ones.
// ----------------------------------------------------------------------------
module irc_front #(
    parameter int ADDRESS_BITS = 32
) (
    input  logic                 range_valid,
    output logic                 range_stall,
    input  irc_pkg::range_t      range_item,
    input  irc_pkg::queue_stat_t qstat,
    output logic                 push,
    output irc_pkg::walk_cmd_t   push_cmd
);
    import irc_pkg::*;

    logic [ADDRESS_BITS-1:0] start_addr;
    logic [ADDRESS_BITS-1:0] stop_addr;

    always_comb
    begin
        start_addr = ADDRESS_BITS'(range_item.range_start);
        stop_addr  = ADDRESS_BITS'(range_item.range_end);
    end

    assign range_stall  = qstat.full;
    assign push         = range_valid && !qstat.full;
    assign push_cmd.rng = range_item;
    // single-address, empty or inverted range (start >= end): single error result
    assign push_cmd.bad = (start_addr >= stop_addr);

endmodule

// File: rtl/core/irc_queue.sv
// ----------------------------------------------------------------------------
// irc_queue
// Short command queue between the front end and the block walker.
// ----------------------------------------------------------------------------
module irc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  irc_pkg::walk_cmd_t   push_cmd,
    input  logic                 pop,
    output irc_pkg::walk_cmd_t   head_cmd,
    output irc_pkg::queue_stat_t qstat
);
    import irc_pkg::*;

    walk_cmd_t                mem_reg [QueueDepth];
    logic [QueuePtrW-1:0]     wr_ptr_reg;
    logic [QueuePtrW-1:0]     wr_ptr_next;
    logic [QueuePtrW-1:0]     rd_ptr_reg;
    logic [QueuePtrW-1:0]     rd_ptr_next;
    logic [QueueCountW-1:0]   count_reg;
    logic [QueueCountW-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd       = mem_reg[rd_ptr_reg];
    assign qstat.full     = (count_reg == QueueCountW'(QueueDepth));
    assign qstat.nonempty = (count_reg != '0);

endmodule

// File: rtl/core/irc_walk.sv
// ----------------------------------------------------------------------------
// irc_walk
// Walks one range, producing one aligned block per cycle into an output register while not stalled.
// ----------------------------------------------------------------------------
module irc_walk #(
    parameter int ADDRESS_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  irc_pkg::queue_stat_t qstat,
    input  irc_pkg::walk_cmd_t   head_cmd,
    output logic                 pop,
    output logic                 block_valid,
    input  logic                 block_stall,
    output irc_pkg::block_t      block_item
);
    import irc_pkg::*;

    localparam int LenW = ADDRESS_BITS + 1;
    localparam int KW   = $clog2(ADDRESS_BITS + 1);

    logic                    busy_reg;
    logic                    busy_next;
    logic                    bad_reg;
    logic [ADDRESS_BITS-1:0] cursor_reg;
    logic [ADDRESS_BITS-1:0] stop_reg;
    logic [CountBits-1:0]    count_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    block_t                  out_reg;

    logic                    advance;
    logic                    emit;
    logic [LenW-1:0]         span_len;
    logic [LenW-1:0]         smear;
    logic [ADDRESS_BITS-1:0] align_mask;
    logic [ADDRESS_BITS-1:0] fit_mask;
    logic [ADDRESS_BITS-1:0] blk_mask;
    logic [ADDRESS_BITS-1:0] top_addr;
    logic [KW-1:0]           blk_log;
    logic                    last;
    block_t                  result;

    assign advance = !out_valid_reg || !block_stall;
    assign emit    = busy_reg && advance;

    // block mask = min(alignment of cursor, largest power of two within span)
    always_comb
    begin
        span_len = {1'b0, stop_reg} - {1'b0, cursor_reg} + LenW'(1);
        smear    = span_len;
        for (int sh = 1; sh < LenW; sh = sh * 2)
        begin
            smear = smear | (smear >> sh);
        end
        fit_mask   = smear[ADDRESS_BITS:1];
        align_mask = ~cursor_reg & (cursor_reg - ADDRESS_BITS'(1));
        blk_mask   = align_mask & fit_mask;
        top_addr   = cursor_reg | blk_mask;
        blk_log    = '0;
        for (int i = 0; i < ADDRESS_BITS; i++)
        begin
            if (blk_mask[i])
            begin
                blk_log = KW'(i + 1);
            end
        end
        last = (top_addr >= stop_reg) || (count_reg == CountBits'(MaxBlocks - 1));

        if (bad_reg)
        begin
            result.block_base    = '0;
            result.prefix_length = '0;
            result.range_error   = 1'b1;
            result.last_block    = 1'b1;
        end
        else
        begin
            result.block_base    = FieldBits'(cursor_reg);
            result.prefix_length = PrefixBits'(ADDRESS_BITS - int'(blk_log));
            result.range_error   = 1'b0;
            result.last_block    = last;
        end
    end

    // load the next range when idle, or in the same cycle the last block leaves
    assign pop = qstat.nonempty && (!busy_reg || (emit && result.last_block));

    always_comb
    begin
        busy_next = busy_reg;
        if (pop)
        begin
            busy_next = 1'b1;
        end
        else if (emit && result.last_block)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                count_reg <= '0;
            end
            else if (emit)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cursor_reg <= ADDRESS_BITS'(head_cmd.rng.range_start);
            stop_reg   <= ADDRESS_BITS'(head_cmd.rng.range_end);
            bad_reg    <= head_cmd.bad;
        end
        else if (emit)
        begin
            cursor_reg <= top_addr + ADDRESS_BITS'(1);
        end
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign block_valid = out_valid_reg;
    assign block_item  = out_reg;

endmodule

// File: rtl/core/irc_checker.sv
// ----------------------------------------------------------------------------
// irc_checker
// Port-level checks for the CIDR block decomposer, bound to the top level.
// ----------------------------------------------------------------------------
module irc_checker #(
    parameter int ADDRESS_BITS = 32
) (
    input logic            clk,
    input logic            rst_n,
    input logic            range_valid,
    input logic            range_stall,
    input irc_pkg::range_t range_item,
    input logic            block_valid,
    input logic            block_stall,
    input irc_pkg::block_t block_item
);
    import irc_pkg::*;

    // a held result keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        block_valid && block_stall |=> block_valid && $stable(block_item))
    else $error("block result changed while stalled");

    // rejected ranges give a single, zeroed, closing result
    assert property (@(posedge clk) disable iff (!rst_n)
        block_valid && block_item.range_error |->
            block_item.last_block && block_item.block_base == '0 &&
            block_item.prefix_length == '0)
    else $error("malformed error result");

    // prefix never exceeds the address width
    assert property (@(posedge clk) disable iff (!rst_n)
        block_valid |-> int'(block_item.prefix_length) <= ADDRESS_BITS)
    else $error("prefix length out of range");

    // a stalled range must be held stable by the source until it is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        range_valid && range_stall |=> range_valid && $stable(range_item) ||
            !$past(range_valid))
    else $error("range input dropped while stalled");

endmodule

bind ip_range_to_cidr_blocks irc_checker #(
    .ADDRESS_BITS (ADDRESS_BITS)
) u_irc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .range_valid (range_valid),
    .range_stall (range_stall),
    .range_item  (range_item),
    .block_valid (block_valid),
    .block_stall (block_stall),
    .block_item  (block_item)
);
